>>> rtl/core/ght_pkg.sv
`default_nettype none

package ght_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int HSLOT_W = 11;
    localparam int GEN_W   = 16;
    localparam int BYTES_W = 32;
    localparam int SUM_W   = 48;

    localparam logic [GEN_W-1:0] LAST_GEN = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_STORE   = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_RESOLVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_REMOVE,
        OP_RESOLVE,
        OP_REJECT
    } t_op;

    typedef enum logic [1:0] {
        SRC_STACK,
        SRC_FRESH,
        SRC_NONE
    } t_src;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [HSLOT_W-1:0] handle_slot;
        logic [GEN_W-1:0]   handle_generation;
        logic [BYTES_W-1:0] entry_bytes;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [9:0]         out_slot;
        logic [GEN_W-1:0]   out_generation;
        logic               slot_retired;
        logic [CNT_W-1:0]   live_total;
        logic [SUM_W-1:0]   bytes_total;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic [BYTES_W-1:0] bytes;
    } t_work;

    typedef struct packed {
        logic               live;
        logic [GEN_W-1:0]   gen;
        logic [BYTES_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
    } t_free;

endpackage

`default_nettype wire

>>> rtl/core/ght_ram.sv
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/ght_fifo.sv
`default_nettype none

module ght_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ght_front.sv
`default_nettype none

module ght_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire ght_pkg::t_in_item i_item,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output ght_pkg::t_work        o_work
);

    import ght_pkg::*;

    t_work cls;
    logic  slot_ok;
    logic  q_empty;

    assign slot_ok = (i_item.handle_slot < HSLOT_W'(SLOTS));

    always_comb begin
        cls.slot  = i_item.handle_slot[SLOT_W-1:0];
        cls.gen   = i_item.handle_generation;
        cls.bytes = i_item.entry_bytes;
        unique case (i_item.cmd)
            CMD_STORE:   cls.op = OP_STORE;
            CMD_REMOVE:  cls.op = slot_ok ? OP_REMOVE : OP_REJECT;
            CMD_RESOLVE: cls.op = slot_ok ? OP_RESOLVE : OP_REJECT;
            default:     cls.op = OP_REJECT;
        endcase
    end

    ght_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_work),
        .o_empty (q_empty)
    );

    assign o_valid = !q_empty;

endmodule

`default_nettype wire

>>> rtl/core/ght_back.sv
`default_nettype none

module ght_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire ght_pkg::t_work i_work,
    output logic                o_q_pop,
    input  wire logic           i_res_full,
    output logic                o_res_valid,
    output ght_pkg::t_out_item  o_result
);

    import ght_pkg::*;

    t_state r_state, n_state;
    t_work  r_work;
    t_src   r_src, n_src;

    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_live, n_live;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] free_m1;

    logic              start;
    logic              entry_re, entry_we;
    logic [SLOT_W-1:0] entry_raddr, entry_waddr;
    t_entry            entry_rdata, entry_wdata;
    logic              stack_re, stack_we;
    logic [SLOT_W-1:0] stack_raddr, stack_waddr;
    t_free             stack_rdata, stack_wdata;
    logic              handle_ok;
    logic [SLOT_W-1:0] new_slot;
    logic [GEN_W-1:0]  new_gen;
    logic              got;
    t_out_item         res;

    assign free_m1 = r_free - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        start       = (r_state == S_IDLE) && i_q_valid && !i_res_full;
        entry_re    = start && (i_work.op == OP_REMOVE || i_work.op == OP_RESOLVE);
        entry_raddr = i_work.slot;
        stack_re    = start && (i_work.op == OP_STORE) && (r_free != '0);
        stack_raddr = free_m1[SLOT_W-1:0];
        if (r_free != '0) begin
            n_src = SRC_STACK;
        end else if (r_used < CNT_W'(SLOTS)) begin
            n_src = SRC_FRESH;
        end else begin
            n_src = SRC_NONE;
        end
    end

    assign o_q_pop = start;

    always_comb begin
        n_free      = r_free;
        n_used      = r_used;
        n_live      = r_live;
        n_sum       = r_sum;
        entry_we    = 1'b0;
        entry_waddr = r_work.slot;
        entry_wdata = '0;
        stack_we    = 1'b0;
        stack_waddr = r_free[SLOT_W-1:0];
        stack_wdata = '0;
        new_slot    = '0;
        new_gen     = '0;
        got         = 1'b0;
        res         = '0;
        res.status  = STAT_STALE;
        handle_ok   = (CNT_W'(r_work.slot) < r_used) && entry_rdata.live
                      && (entry_rdata.gen == r_work.gen);
        if (r_state == S_EXEC) begin
            case (r_work.op)
                OP_STORE: begin
                    case (r_src)
                        SRC_STACK: begin
                            got      = 1'b1;
                            new_slot = stack_rdata.slot;
                            new_gen  = stack_rdata.gen;
                            n_free   = free_m1;
                        end
                        SRC_FRESH: begin
                            got      = 1'b1;
                            new_slot = r_used[SLOT_W-1:0];
                            n_used   = r_used + CNT_W'(1);
                        end
                        default: got = 1'b0;
                    endcase
                    if (got) begin
                        entry_we           = 1'b1;
                        entry_waddr        = new_slot;
                        entry_wdata.live   = 1'b1;
                        entry_wdata.gen    = new_gen;
                        entry_wdata.size   = r_work.bytes;
                        n_live             = r_live + CNT_W'(1);
                        n_sum              = r_sum + SUM_W'(r_work.bytes);
                        res.status         = STAT_OK;
                        res.out_slot       = 10'(new_slot);
                        res.out_generation = new_gen;
                    end else begin
                        res.status = STAT_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (handle_ok) begin
                        entry_we   = 1'b1;
                        n_sum      = r_sum - SUM_W'(entry_rdata.size);
                        res.status = STAT_OK;
                        if (r_live != '0) begin
                            n_live = r_live - CNT_W'(1);
                        end
                        if (entry_rdata.gen == LAST_GEN) begin
                            entry_wdata.gen  = LAST_GEN;
                            res.slot_retired = 1'b1;
                        end else begin
                            entry_wdata.gen = entry_rdata.gen + GEN_W'(1);
                            if (r_free < CNT_W'(SLOTS)) begin
                                stack_we         = 1'b1;
                                stack_wdata.slot = r_work.slot;
                                stack_wdata.gen  = entry_rdata.gen + GEN_W'(1);
                                n_free           = r_free + CNT_W'(1);
                            end
                        end
                    end
                end
                OP_RESOLVE: begin
                    if (handle_ok) begin
                        res.status = STAT_OK;
                    end
                end
                default: res.status = STAT_STALE;
            endcase
        end
        res.live_total  = n_live;
        res.bytes_total = n_sum;
    end

    assign o_res_valid = (r_state == S_EXEC);
    assign o_result    = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_used  <= '0;
            r_live  <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_used  <= n_used;
            r_live  <= n_live;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_work <= i_work;
            r_src  <= n_src;
        end
    end

    ght_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (entry_waddr),
        .i_wdata (entry_wdata),
        .i_re    (entry_re),
        .i_raddr (entry_raddr),
        .o_rdata (entry_rdata)
    );

    ght_ram #(
        .WIDTH ($bits(t_free)),
        .DEPTH (SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_re    (stack_re),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    a_exec_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> $past(start))
        else $error("exec without start");

    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live count above used slots");

    a_free_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_free} + {1'b0, r_live}) <= {1'b0, r_used})
        else $error("free plus live above used slots");

    a_retire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.slot_retired |->
            o_result.status == STAT_OK && r_work.op == OP_REMOVE)
        else $error("retire flagged on failed item");

endmodule

`default_nettype wire

>>> rtl/core/generational_handle_table.sv
`default_nettype none
// Channel   Handshake            Payload
// input     push / full          i_item   (cmd, handle, entry_bytes)
// result    empty / pop          o_result (status, handle, totals)
//
// In the back end each item goes through a registered read of the slot
// entry or free stack top, then write back and result.
// Front queue holds 2 classified items; result queue holds 2 items.
// Back end starts an item only when the result queue has room.
// No clearing pass after reset: entry data at or above the used-slot count is ignored.

module generational_handle_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ght_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output ght_pkg::t_out_item      o_result
);

    import ght_pkg::*;

    logic      q_valid, q_pop;
    t_work     work;
    logic      res_valid, res_full;
    t_out_item result;

    ght_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_work  (work)
    );

    ght_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_work      (work),
        .o_q_pop     (q_pop),
        .i_res_full  (res_full),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    ght_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (2)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
